@@ hw/rtl/tlpq_pkg.sv @@
// shared types, codes and defaults for the three-level priority queue
package tlpq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DEF_TAG_BITS = 16;
  localparam int NUM_LEVELS   = 3;

  localparam int ACT_W  = 2;
  localparam int LVL_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLR = 2'd2;

  localparam logic [LVL_W-1:0] LVL_HIGH   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_NORMAL = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LOW    = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

@@ hw/rtl/three_level_stable_priority_queue_unit.sv @@
// top level of the three-level stable priority queue
// Command-style unit. Drive in_action, in_level and in_tag with start high;
// the item is taken at a rising edge where start is high and busy is low.
// Actions: enqueue a tag at a level (high, normal, low; code 3 acts as low),
// dequeue the oldest entry of the highest non-empty level, or clear all.
// Each level is a ring of CAPACITY slots in one shared slot memory, with its
// own head pointer and count, so no entry ever moves.
// The result (status, out_tag, out_level, out_occupancy) is registered at the
// end of the execute cycle, appears on the ports and stays there for one cycle,
// marked by out_valid; it is taken at the edge that ends that cycle.
// The receiver cannot stall; it must take it in that cycle.
// Each item takes an execute step against the slot memory, whose read port is
// registered, and a step to present the result, during which the next item
// may already be accepted. busy is high only in the execute cycle.
// Synchronous reset (rst_n low) empties all levels and returns to idle;
// slot contents are left as they are and are never read before written.
module three_level_stable_priority_queue_unit #(
  parameter int CAPACITY = tlpq_pkg::DEF_CAPACITY,
  parameter int TAG_BITS = tlpq_pkg::DEF_TAG_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [tlpq_pkg::ACT_W-1:0]     in_action,
  input  logic [tlpq_pkg::LVL_W-1:0]     in_level,
  input  logic [TAG_BITS-1:0]            in_tag,
  output logic                           out_valid,
  output logic [tlpq_pkg::STAT_W-1:0]    out_status,
  output logic [TAG_BITS-1:0]            out_tag,
  output logic [tlpq_pkg::LVL_W-1:0]     out_level,
  output logic [$clog2(CAPACITY+1)-1:0]  out_occupancy
);
  import tlpq_pkg::*;

  ctrl_cmd_t cmd;

  tlpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tlpq_dp #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_action     (in_action),
    .in_level      (in_level),
    .in_tag        (in_tag),
    .out_status    (out_status),
    .out_tag       (out_tag),
    .out_level     (out_level),
    .out_occupancy (out_occupancy)
  );

endmodule

@@ hw/rtl/tlpq_ctrl.sv @@
// controller state machine: sequences accept, execute and result strobe
module tlpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output tlpq_pkg::ctrl_cmd_t cmd
);
  import tlpq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // a new item may be taken while the result is on the ports
        state_nxt = start ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    cmd.exec  = 1'b0;
    case (state_r)
      S_IDLE: begin
      end
      S_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      S_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
    cmd.load = start && !busy;
  end

endmodule

@@ hw/rtl/tlpq_dp.sv @@
// datapath: per-level ring pointers, counts and the slot memory
module tlpq_dp #(
  parameter int CAPACITY = tlpq_pkg::DEF_CAPACITY,
  parameter int TAG_BITS = tlpq_pkg::DEF_TAG_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tlpq_pkg::ctrl_cmd_t            cmd,
  input  logic [tlpq_pkg::ACT_W-1:0]     in_action,
  input  logic [tlpq_pkg::LVL_W-1:0]     in_level,
  input  logic [TAG_BITS-1:0]            in_tag,
  output logic [tlpq_pkg::STAT_W-1:0]    out_status,
  output logic [TAG_BITS-1:0]            out_tag,
  output logic [tlpq_pkg::LVL_W-1:0]     out_level,
  output logic [$clog2(CAPACITY+1)-1:0]  out_occupancy
);
  import tlpq_pkg::*;

  localparam int PTR_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DEPTH  = NUM_LEVELS * CAPACITY;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [PTR_W:0]    CAP_P  = (PTR_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0]  CAP_C  = CNT_W'(CAPACITY);
  localparam logic [ADDR_W-1:0] BASE_1 = ADDR_W'(CAPACITY);
  localparam logic [ADDR_W-1:0] BASE_2 = ADDR_W'(2 * CAPACITY);

  logic [ACT_W-1:0]    act_r;
  logic [LVL_W-1:0]    lvl_r;
  logic [TAG_BITS-1:0] tag_r;

  logic [PTR_W-1:0] head_r   [NUM_LEVELS];
  logic [PTR_W-1:0] head_nxt [NUM_LEVELS];
  logic [CNT_W-1:0] count_r  [NUM_LEVELS];
  logic [CNT_W-1:0] count_nxt[NUM_LEVELS];
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] total_nxt;

  logic [STAT_W-1:0] status_r;
  logic [STAT_W-1:0] status_nxt;
  logic [LVL_W-1:0]  olvl_r;
  logic [LVL_W-1:0]  olvl_nxt;
  logic              hit_r;
  logic              hit_nxt;

  logic [TAG_BITS-1:0] mem [DEPTH];
  logic [TAG_BITS-1:0] rdata_r;
  logic                we;
  logic                re;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;

  logic [LVL_W-1:0] enq_lvl;
  logic [PTR_W-1:0] enq_head;
  logic [CNT_W-1:0] enq_cnt;
  logic [PTR_W-1:0] enq_pos;
  logic [LVL_W-1:0] deq_lvl;
  logic [PTR_W-1:0] deq_head;
  logic             found;
  logic [CNT_W+1:0] count_sum;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CAP_P) s = s - CAP_P;
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] l,
                                                  input logic [PTR_W-1:0] p);
    logic [ADDR_W-1:0] base;
    case (l)
      LVL_HIGH:   base = '0;
      LVL_NORMAL: base = BASE_1;
      default:    base = BASE_2;
    endcase
    return base + ADDR_W'(p);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      lvl_r <= in_level;
      tag_r <= in_tag;
    end
  end

  // level code 3 is taken as low
  assign enq_lvl = (lvl_r > LVL_LOW) ? LVL_LOW : lvl_r;

  always_comb begin
    enq_head = '0;
    enq_cnt  = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (enq_lvl == LVL_W'(l)) begin
        enq_head = head_r[l];
        enq_cnt  = count_r[l];
      end
    end
  end

  // count stays below capacity when not full, so the low bits are the offset
  assign enq_pos = ring_add(enq_head, enq_cnt[PTR_W-1:0]);

  // highest non-empty level wins: scan low to high so level 0 lands last
  always_comb begin
    deq_lvl  = LVL_HIGH;
    deq_head = '0;
    found    = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (count_r[l] != '0) begin
        deq_lvl  = LVL_W'(l);
        deq_head = head_r[l];
        found    = 1'b1;
      end
    end
  end

  assign wr_addr = slot_addr(enq_lvl, enq_pos);
  assign rd_addr = slot_addr(deq_lvl, deq_head);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    status_nxt = ST_OK;
    olvl_nxt   = LVL_HIGH;
    hit_nxt    = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    case (act_r)
      ACT_ENQ: begin
        if (total_r >= CAP_C) begin
          status_nxt = ST_FULL;
        end else begin
          we        = cmd.exec;
          total_nxt = total_r + 1'b1;
          for (int l = 0; l < NUM_LEVELS; l++) begin
            if (enq_lvl == LVL_W'(l)) count_nxt[l] = count_r[l] + 1'b1;
          end
        end
      end
      ACT_DEQ: begin
        if (!found) begin
          status_nxt = ST_EMPTY;
        end else begin
          re        = cmd.exec;
          hit_nxt   = 1'b1;
          olvl_nxt  = deq_lvl;
          total_nxt = total_r - 1'b1;
          for (int l = 0; l < NUM_LEVELS; l++) begin
            if (deq_lvl == LVL_W'(l)) begin
              head_nxt[l]  = ring_add(head_r[l], PTR_W'(1));
              count_nxt[l] = count_r[l] - 1'b1;
            end
          end
        end
      end
      ACT_CLR: begin
        total_nxt = '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
          head_nxt[l]  = '0;
          count_nxt[l] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_r[l]  <= '0;
        count_r[l] <= '0;
      end
    end else if (cmd.exec) begin
      total_r <= total_nxt;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_r[l]  <= head_nxt[l];
        count_r[l] <= count_nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      olvl_r   <= olvl_nxt;
      hit_r    <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= tag_r;
    if (re) rdata_r <= mem[rd_addr];
  end

  assign out_status    = status_r;
  assign out_level     = olvl_r;
  assign out_tag       = hit_r ? rdata_r : '0;
  assign out_occupancy = total_r;

  assign count_sum = (CNT_W + 2)'(count_r[0]) + (CNT_W + 2)'(count_r[1])
                   + (CNT_W + 2)'(count_r[2]);

  a_total_is_sum: assert property (@(posedge clk) disable iff (!rst_n)
    count_sum == (CNT_W + 2)'(total_r))
    else $error("total count differs from the sum of level counts");

  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CAP_C)
    else $error("queue holds more than capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && act_r == ACT_CLR) |=> (total_r == '0))
    else $error("clear left entries behind");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && act_r == ACT_ENQ && total_r == CAP_C) |=> $stable(total_r))
    else $error("enqueue into a full queue changed occupancy");

endmodule

@@ bench/tb.sv @@
// self-checking testbench for the three-level stable priority queue unit
`timescale 1ns / 100ps

module tb;
  import tlpq_pkg::*;

  localparam int CAP        = DEF_CAPACITY;
  localparam int TAGW       = DEF_TAG_BITS;
  localparam int OCCW       = $clog2(CAP + 1);
  localparam int DIR_ROWS   = 23;
  localparam int PHASE_ITEMS = 550;
  localparam int TAIL_CYCLES = 6;
  localparam int CYCLE_LIMIT = 200000;

  // codes the package leaves unnamed
  localparam logic [ACT_W-1:0] ACT_NOP       = 2'd3;
  localparam logic [LVL_W-1:0] LVL_LOW_ALIAS = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TAGW-1:0]   tag;
    logic [LVL_W-1:0]  level;
    logic [OCCW-1:0]   occ;
  } queue_reply_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [LVL_W-1:0] lvl;
    logic [TAGW-1:0]  tag;
    logic             fixed;
    queue_reply_t     want;
  } dir_row_t;

  logic            clk;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [ACT_W-1:0] in_action = ACT_NOP;
  logic [LVL_W-1:0] in_level = LVL_HIGH;
  logic [TAGW-1:0]  in_tag = '0;
  logic             out_valid;
  logic [STAT_W-1:0] out_status;
  logic [TAGW-1:0]   out_tag;
  logic [LVL_W-1:0]  out_level;
  logic [OCCW-1:0]   out_occupancy;

  // typed-in expectation that travels with the item being offered
  logic         row_fixed = 1'b0;
  queue_reply_t row_want = '0;

  // shadow of the queue contents
  logic [TAGW-1:0] slot_store [NUM_LEVELS][CAP];
  int              lvl_head [NUM_LEVELS];
  int              lvl_count [NUM_LEVELS];
  int              held_total;

  queue_reply_t pending_replies [$];
  int mismatches = 0;
  int cycle_count = 0;
  int n_enq = 0, n_full = 0, n_deq = 0, n_empty = 0, n_clr = 0, n_nop = 0;
  int gap_pct = 0;

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ACT_DEQ, LVL_HIGH,      16'h0000, 1'b1, '{ST_EMPTY, 16'h0000, LVL_HIGH,   5'd0}},
    '{ACT_CLR, LVL_HIGH,      16'h0000, 1'b1, '{ST_OK,    16'h0000, LVL_HIGH,   5'd0}},
    '{ACT_NOP, LVL_HIGH,      16'hffff, 1'b1, '{ST_OK,    16'h0000, LVL_HIGH,   5'd0}},
    '{ACT_ENQ, LVL_LOW,       16'hffff, 1'b1, '{ST_OK,    16'h0000, LVL_HIGH,   5'd1}},
    '{ACT_ENQ, LVL_LOW_ALIAS, 16'h0001, 1'b1, '{ST_OK,    16'h0000, LVL_HIGH,   5'd2}},
    '{ACT_ENQ, LVL_NORMAL,    16'h0000, 1'b1, '{ST_OK,    16'h0000, LVL_HIGH,   5'd3}},
    '{ACT_ENQ, LVL_HIGH,      16'h8000, 1'b1, '{ST_OK,    16'h0000, LVL_HIGH,   5'd4}},
    '{ACT_ENQ, LVL_HIGH,      16'h7fff, 1'b1, '{ST_OK,    16'h0000, LVL_HIGH,   5'd5}},
    '{ACT_NOP, LVL_LOW,       16'h5a5a, 1'b1, '{ST_OK,    16'h0000, LVL_HIGH,   5'd5}},
    '{ACT_DEQ, LVL_LOW,       16'h0000, 1'b1, '{ST_OK,    16'h8000, LVL_HIGH,   5'd4}},
    '{ACT_DEQ, LVL_HIGH,      16'h0000, 1'b1, '{ST_OK,    16'h7fff, LVL_HIGH,   5'd3}},
    '{ACT_ENQ, LVL_HIGH,      16'h00ff, 1'b0, '0},
    '{ACT_DEQ, LVL_NORMAL,    16'h1111, 1'b0, '0},
    '{ACT_DEQ, LVL_HIGH,      16'h0000, 1'b1, '{ST_OK,    16'h0000, LVL_NORMAL, 5'd2}},
    '{ACT_DEQ, LVL_HIGH,      16'h0000, 1'b1, '{ST_OK,    16'hffff, LVL_LOW,    5'd1}},
    '{ACT_DEQ, LVL_HIGH,      16'h0000, 1'b1, '{ST_OK,    16'h0001, LVL_LOW,    5'd0}},
    '{ACT_DEQ, LVL_HIGH,      16'h0000, 1'b1, '{ST_EMPTY, 16'h0000, LVL_HIGH,   5'd0}},
    '{ACT_ENQ, LVL_NORMAL,    16'h1234, 1'b1, '{ST_OK,    16'h0000, LVL_HIGH,   5'd1}},
    '{ACT_ENQ, LVL_LOW,       16'habcd, 1'b0, '0},
    '{ACT_CLR, LVL_HIGH,      16'h0000, 1'b1, '{ST_OK,    16'h0000, LVL_HIGH,   5'd0}},
    '{ACT_DEQ, LVL_HIGH,      16'h0000, 1'b1, '{ST_EMPTY, 16'h0000, LVL_HIGH,   5'd0}},
    '{ACT_ENQ, LVL_LOW,       16'hc3c3, 1'b1, '{ST_OK,    16'h0000, LVL_HIGH,   5'd1}},
    '{ACT_DEQ, LVL_HIGH,      16'h0000, 1'b1, '{ST_OK,    16'hc3c3, LVL_LOW,    5'd0}}
  };

  three_level_stable_priority_queue_unit #(
    .CAPACITY(CAP),
    .TAG_BITS(TAGW)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_level(in_level),
    .in_tag(in_tag),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_tag(out_tag),
    .out_level(out_level),
    .out_occupancy(out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               pending_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // applies one command to the shadow queue and returns the reply it causes
  function automatic queue_reply_t apply_queue_op(logic [ACT_W-1:0] act,
                                                  logic [LVL_W-1:0] lvl_in,
                                                  logic [TAGW-1:0] tg);
    queue_reply_t r;
    int lv;
    int slot;
    bit found;
    r = '0;
    found = 1'b0;
    lv = (lvl_in == LVL_LOW_ALIAS) ? int'(LVL_LOW) : int'(lvl_in);
    case (act)
      ACT_ENQ: begin
        if (held_total >= CAP) begin
          r.status = ST_FULL;
        end else begin
          slot = (lvl_head[lv] + lvl_count[lv]) % CAP;
          slot_store[lv][slot] = tg;
          lvl_count[lv]++;
          held_total++;
        end
      end
      ACT_DEQ: begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
          if (!found && lvl_count[l] != 0) begin
            r.tag = slot_store[l][lvl_head[l]];
            r.level = LVL_W'(l);
            lvl_head[l] = (lvl_head[l] + 1) % CAP;
            lvl_count[l]--;
            held_total--;
            found = 1'b1;
          end
        end
        if (!found) r.status = ST_EMPTY;
      end
      ACT_CLR: begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
          lvl_head[l] = 0;
          lvl_count[l] = 0;
        end
        held_total = 0;
      end
      default: ;
    endcase
    r.occ = OCCW'(held_total);
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    queue_reply_t want;
    queue_reply_t got;
    queue_reply_t pred;
    if (rst_n) begin
      if (out_valid) begin
        got = '{out_status, out_tag, out_level, out_occupancy};
        if (pending_replies.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected reply: status %0d tag %h level %0d occupancy %0d",
                     got.status, got.tag, got.level, got.occ);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          if (got != want) begin
            if (mismatches < 10)
              $display({"mismatch: expected status %0d tag %h level %0d occupancy %0d,",
                        " got %0d %h %0d %0d"},
                       want.status, want.tag, want.level, want.occ,
                       got.status, got.tag, got.level, got.occ);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        pred = apply_queue_op(in_action, in_level, in_tag);
        case (in_action)
          ACT_ENQ: if (pred.status == ST_FULL) n_full++; else n_enq++;
          ACT_DEQ: if (pred.status == ST_EMPTY) n_empty++; else n_deq++;
          ACT_CLR: n_clr++;
          default: n_nop++;
        endcase
        pending_replies.push_back(row_fixed ? row_want : pred);
      end
    end
  end

  // offers one item, idling first at the current rate, and returns at the accepting edge
  task automatic offer_item(logic [ACT_W-1:0] act, logic [LVL_W-1:0] lvl,
                            logic [TAGW-1:0] tg, logic fixed, queue_reply_t want);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_level <= lvl;
    in_tag <= tg;
    row_fixed <= fixed;
    row_want <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_queue();
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int sent;
    int mode;
    int burst;
    int pick;
    logic [ACT_W-1:0] act;
    logic [TAGW-1:0]  tg;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      lvl_head[l] = 0;
      lvl_count[l] = 0;
    end
    held_total = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      offer_item(directed_rows[i].act, directed_rows[i].lvl, directed_rows[i].tag,
                 directed_rows[i].fixed, directed_rows[i].want);
    drain_queue();

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 33 : (phase == 1) ? 86 : 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // bursts that fill, drain or mix, so full and empty both come up often
        mode = $urandom_range(2);
        burst = $urandom_range(40, 4);
        for (int k = 0; k < burst; k++) begin
          pick = $urandom_range(99);
          case (mode)
            0: act = (pick < 88) ? ACT_ENQ : (pick < 96) ? ACT_DEQ :
                     (pick < 98) ? ACT_CLR : ACT_NOP;
            1: act = (pick < 85) ? ACT_DEQ : (pick < 95) ? ACT_ENQ :
                     (pick < 98) ? ACT_CLR : ACT_NOP;
            default: act = (pick < 50) ? ACT_ENQ : (pick < 92) ? ACT_DEQ :
                           (pick < 96) ? ACT_CLR : ACT_NOP;
          endcase
          tg = TAGW'($urandom);
          if ($urandom_range(19) == 0) tg = $urandom_range(1) ? '1 : '0;
          offer_item(act, LVL_W'($urandom_range(3)), tg, 1'b0, '0);
          if (act != ACT_NOP) sent++;
        end
      end
      drain_queue();
    end

    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d enqueues plus %0d refused as full, %0d dequeues plus %0d on empty,",
             n_enq, n_full, n_deq, n_empty);
    $display("%0d clears and %0d no-ops, with idle rates 33, 86 and 0 percent; %0d mismatches",
             n_clr, n_nop, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ three_level_stable_priority_queue_unit.f @@
hw/rtl/tlpq_pkg.sv
hw/rtl/tlpq_ctrl.sv
hw/rtl/tlpq_dp.sv
hw/rtl/three_level_stable_priority_queue_unit.sv
bench/tb.sv
